### rtl/core/idll_pkg.sv
package idll_pkg;

	// Longest dump: the walk stops after this many ids.
	localparam int MAX_RESULTS = 63;
	localparam int OUT_ID_W    = 6;

	typedef enum logic [1:0] {
		OP_INS_RIGHT = 2'd0,
		OP_INS_LEFT  = 2'd1,
		OP_REMOVE    = 2'd2,
		OP_DUMP      = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_REFUSED = 2'd1,
		STAT_EMPTY   = 2'd2
	} status_t;

	// Which result the datapath registers this cycle.
	typedef enum logic [2:0] {
		RES_NONE,
		RES_NEW,
		RES_REFUSE,
		RES_DONE,
		RES_EMPTY,
		RES_WALK
	} res_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_EXEC,
		S_LINK,
		S_WALK
	} state_t;

	typedef struct packed {
		logic init;
		logic accept;
		logic phase_a;
		logic phase_b;
		logic walk;
		res_t res;
	} cmd_t;

	typedef struct packed {
		opcode_t op;
		logic    ok_ins;
		logic    ok_rem;
		logic    head_empty;
		logic    walk_last;
	} stat_t;

endpackage

### rtl/core/idll_ctrl.sv
module idll_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  idll_pkg::stat_t stat,
	output idll_pkg::cmd_t  cmd
);
	import idll_pkg::*;

	state_t st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_INIT;
		end else begin
			st_q <= st_d;
		end
	end

	// Next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			S_INIT: st_d = S_IDLE;
			S_IDLE: begin
				if (start) begin
					st_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (stat.op)
					OP_INS_RIGHT, OP_INS_LEFT: st_d = stat.ok_ins ? S_LINK : S_IDLE;
					OP_REMOVE:                 st_d = stat.ok_rem ? S_LINK : S_IDLE;
					OP_DUMP: begin
						if (stat.head_empty || stat.walk_last) begin
							st_d = S_IDLE;
						end else begin
							st_d = S_WALK;
						end
					end
					default: st_d = S_IDLE;
				endcase
			end
			S_WALK: begin
				if (stat.walk_last) begin
					st_d = S_IDLE;
				end
			end
			S_LINK:  st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd  = '{init: 1'b0, accept: 1'b0, phase_a: 1'b0, phase_b: 1'b0, walk: 1'b0,
			res: RES_NONE};
		busy = (st_q != S_IDLE);
		case (st_q)
			S_INIT: cmd.init = 1'b1;
			S_IDLE: cmd.accept = start;
			S_EXEC: begin
				case (stat.op)
					OP_INS_RIGHT, OP_INS_LEFT: begin
						if (stat.ok_ins) begin
							cmd.phase_a = 1'b1;
						end else begin
							cmd.res = RES_REFUSE;
						end
					end
					OP_REMOVE: begin
						if (stat.ok_rem) begin
							cmd.phase_a = 1'b1;
						end else begin
							cmd.res = RES_DONE;
						end
					end
					OP_DUMP: begin
						if (stat.head_empty) begin
							cmd.res = RES_EMPTY;
						end else begin
							cmd.walk = 1'b1;
							cmd.res  = RES_WALK;
						end
					end
					default: cmd.res = RES_NONE;
				endcase
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				cmd.res  = RES_WALK;
			end
			S_LINK: begin
				cmd.phase_b = 1'b1;
				cmd.res     = (stat.op == OP_REMOVE) ? RES_DONE : RES_NEW;
			end
			default: cmd.res = RES_NONE;
		endcase
	end

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_IDLE && start |=> st_q == S_EXEC)
		else $error("accepted transaction did not enter lookup");

	a_link_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_LINK |=> st_q == S_IDLE)
		else $error("link phase did not return to idle");

endmodule

### rtl/core/idll_dp.sv
module idll_dp #(
	parameter int NODES = 63
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [1:0]     opcode,
	input  logic [5:0]     ref_node,
	input  idll_pkg::cmd_t cmd,
	output idll_pkg::stat_t stat,
	output logic           strobe,
	output logic [5:0]     node_id,
	output logic [1:0]     status,
	output logic           last
);
	import idll_pkg::*;

	localparam int IW  = $clog2(NODES + 1);
	localparam int NUW = $clog2(NODES + 2);

	logic [IW-1:0] next_mem [NODES+1];
	logic [IW-1:0] prev_mem [NODES+1];
	logic          in_mem   [NODES+1];

	logic [IW-1:0]  next_rd_q, prev_rd_q;
	logic           in_rd_q, rd_fresh_q;
	logic [IW-1:0]  head_q;
	logic [NUW-1:0] next_unused_q;
	opcode_t        op_q;
	logic [5:0]     ref_q;
	logic [IW-1:0]  cur_q, a_q, b_q;
	logic [5:0]     cnt_q;
	logic           strobe_q;
	logic [5:0]     node_id_q;
	status_t        status_q;
	logic           last_q;

	logic [IW-1:0] next_v, prev_v, r, nw, rd_addr;
	logic          in_v, rd_en, range_ok, full;
	logic          n_we, p_we, i_we, i_wd;
	logic [IW-1:0] n_wa, n_wd, p_wa, p_wd, i_wa;

	// Entries at or above the next unused id were never written: read as none.
	assign next_v = rd_fresh_q ? '0 : next_rd_q;
	assign prev_v = rd_fresh_q ? '0 : prev_rd_q;
	assign in_v   = rd_fresh_q ? 1'b0 : in_rd_q;
	assign r      = IW'(ref_q);
	assign nw     = IW'(next_unused_q);

	assign range_ok = (ref_q != 6'd0) && ({26'd0, ref_q} <= 32'(NODES));
	assign full     = ({{(32-NUW){1'b0}}, next_unused_q} > 32'(NODES));

	always_comb begin
		stat.op         = op_q;
		stat.ok_rem     = range_ok && in_v;
		stat.ok_ins     = range_ok && in_v && !full;
		stat.head_empty = (head_q == '0);
		stat.walk_last  = (next_v == '0) || (cnt_q == 6'(MAX_RESULTS - 1));
	end

	always_comb begin
		rd_en   = cmd.accept || cmd.walk;
		rd_addr = next_v;
		if (cmd.accept) begin
			rd_addr = (opcode_t'(opcode) == OP_DUMP) ? head_q : IW'(ref_node);
		end
	end

	// Link table write ports
	always_comb begin
		n_we = 1'b0; n_wa = '0; n_wd = '0;
		p_we = 1'b0; p_wa = '0; p_wd = '0;
		i_we = 1'b0; i_wa = '0; i_wd = 1'b0;
		if (cmd.init) begin
			n_we = 1'b1; n_wa = IW'(1);
			p_we = 1'b1; p_wa = IW'(1);
			i_we = 1'b1; i_wa = IW'(1); i_wd = 1'b1;
		end else if (cmd.phase_a) begin
			case (op_q)
				OP_INS_RIGHT: begin
					n_we = 1'b1; n_wa = r;  n_wd = nw;
					p_we = 1'b1; p_wa = nw; p_wd = r;
					i_we = 1'b1; i_wa = nw; i_wd = 1'b1;
				end
				OP_INS_LEFT: begin
					n_we = 1'b1; n_wa = nw; n_wd = r;
					p_we = 1'b1; p_wa = r;  p_wd = nw;
					i_we = 1'b1; i_wa = nw; i_wd = 1'b1;
				end
				OP_REMOVE: begin
					n_we = 1'b1; n_wa = r;
					p_we = 1'b1; p_wa = r;
					i_we = 1'b1; i_wa = r;
				end
				default: n_we = 1'b0;
			endcase
		end else if (cmd.phase_b) begin
			case (op_q)
				OP_INS_RIGHT: begin
					n_we = 1'b1;         n_wa = nw;  n_wd = b_q;
					p_we = (b_q != '0);  p_wa = b_q; p_wd = nw;
				end
				OP_INS_LEFT: begin
					p_we = 1'b1;         p_wa = nw;  p_wd = a_q;
					n_we = (a_q != '0);  n_wa = a_q; n_wd = nw;
				end
				OP_REMOVE: begin
					n_we = (a_q != '0);  n_wa = a_q; n_wd = b_q;
					p_we = (b_q != '0);  p_wa = b_q; p_wd = a_q;
				end
				default: n_we = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (n_we) begin
			next_mem[n_wa] <= n_wd;
		end
		if (rd_en) begin
			next_rd_q <= next_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (p_we) begin
			prev_mem[p_wa] <= p_wd;
		end
		if (rd_en) begin
			prev_rd_q <= prev_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (i_we) begin
			in_mem[i_wa] <= i_wd;
		end
		if (rd_en) begin
			in_rd_q <= in_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_fresh_q <= (NUW'(rd_addr) >= next_unused_q);
		end
		if (cmd.accept) begin
			op_q  <= opcode_t'(opcode);
			ref_q <= ref_node;
			cur_q <= head_q;
			cnt_q <= 6'd0;
		end
		if (cmd.phase_a) begin
			a_q <= prev_v;
			b_q <= next_v;
		end
		if (cmd.walk) begin
			cur_q <= next_v;
			cnt_q <= cnt_q + 6'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q        <= IW'(1);
			next_unused_q <= NUW'(2);
			strobe_q      <= 1'b0;
		end else begin
			strobe_q <= (cmd.res != RES_NONE);
			if (cmd.phase_b) begin
				case (op_q)
					OP_INS_RIGHT: next_unused_q <= next_unused_q + NUW'(1);
					OP_INS_LEFT: begin
						next_unused_q <= next_unused_q + NUW'(1);
						if (a_q == '0) begin
							head_q <= nw;
						end
					end
					OP_REMOVE: begin
						if (head_q == r) begin
							head_q <= b_q;
						end
					end
					default: head_q <= head_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.res)
			RES_NEW: begin
				node_id_q <= OUT_ID_W'(nw);
				status_q  <= STAT_OK;
				last_q    <= 1'b1;
			end
			RES_REFUSE: begin
				node_id_q <= 6'd0;
				status_q  <= STAT_REFUSED;
				last_q    <= 1'b1;
			end
			RES_EMPTY: begin
				node_id_q <= 6'd0;
				status_q  <= STAT_EMPTY;
				last_q    <= 1'b1;
			end
			RES_WALK: begin
				node_id_q <= OUT_ID_W'(cur_q);
				status_q  <= STAT_OK;
				last_q    <= stat.walk_last;
			end
			default: begin
				node_id_q <= 6'd0;
				status_q  <= STAT_OK;
				last_q    <= 1'b1;
			end
		endcase
	end

	assign strobe  = strobe_q;
	assign node_id = node_id_q;
	assign status  = status_q;
	assign last    = last_q;

	a_refuse_shape: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && status_q == STAT_REFUSED |-> node_id_q == 6'd0 && last_q)
		else $error("refused insert carried an id or was not last");

	a_id_grows_on_link: assert property (@(posedge clk) disable iff (!arst_n)
		next_unused_q != $past(next_unused_q) |-> $past(cmd.phase_b)
			&& next_unused_q == $past(next_unused_q) + NUW'(1))
		else $error("unused id moved outside an insert link phase");

	a_head_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.phase_b |=> {{(32-IW){1'b0}}, head_q} <= 32'(NODES))
		else $error("head id beyond node count");

endmodule

### rtl/core/indexed_doubly_linked_list_unit.sv
// Ordered list of node ids 1..NODES kept in next/prev link tables (id 0 = none);
// after reset the list holds only node 1. Issue a transaction by raising start
// while busy is low: opcode 0/1 inserts the next unused id right/left of
// ref_node, 2 removes ref_node, 3 dumps the list from the head. Results come
// back on node_id/status/last, each valid for exactly one cycle while strobe
// is high, and are registered in the cycle after the decision; the receiver
// cannot stall, so take every strobe. Every transaction ends with a result
// carrying last. The link tables are single-port, so an insert or remove that
// changes the list goes through a lookup read, an unlink or first link write
// and a second link write before the next accept; a refused insert, a remove
// of an absent node and a dump of an empty list end after the lookup read; a
// dump makes one table read per id. After reset, busy stays high for one cycle
// while node 1's table entries are set up.
module indexed_doubly_linked_list_unit #(
	parameter int NODES = 63
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] opcode,
	input  logic [5:0] ref_node,
	output logic       strobe,
	output logic [5:0] node_id,
	output logic [1:0] status,
	output logic       last
);
	import idll_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Sequencer: lookup, then up to two link-write phases, or a walk.
	idll_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	// Link tables, head and id allocation, result register.
	idll_dp #(
		.NODES (NODES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.opcode   (opcode),
		.ref_node (ref_node),
		.cmd      (cmd),
		.stat     (stat),
		.strobe   (strobe),
		.node_id  (node_id),
		.status   (status),
		.last     (last)
	);

endmodule

### tb/tb.sv
module tb;
	import idll_pkg::*;

	localparam int LIST_SIZE    = 63;
	localparam int REPORT_LIMIT = 10;

	// One command as the sender presents it.
	typedef struct {
		opcode_t    op;
		logic [5:0] ref_id;
		bit         drain_first;  // hold off until every outstanding result is back
	} txn_t;

	// One result the block owes us.
	typedef struct {
		logic [5:0] id;
		status_t    st;
		logic       fin;
	} list_result_t;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       start    = 1'b0;
	logic       busy;
	opcode_t    opcode   = OP_DUMP;
	logic [5:0] ref_node = '0;
	logic       strobe;
	logic [5:0] node_id;
	logic [1:0] status;
	logic       last;

	indexed_doubly_linked_list_unit #(
		.NODES(LIST_SIZE)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.opcode  (opcode),
		.ref_node(ref_node),
		.strobe  (strobe),
		.node_id (node_id),
		.status  (status),
		.last    (last)
	);

	always #1 clk = ~clk;

	// Shadow copy of the list: link tables, membership, head and next free id.
	logic [5:0] nxt_tab [0:LIST_SIZE];
	logic [5:0] prv_tab [0:LIST_SIZE];
	bit         on_list [0:LIST_SIZE];
	logic [5:0] head_id;
	logic [6:0] fresh_id;

	// Stimulus planning only tracks which ids will be live, so that most
	// references can be chosen to hit the list.
	bit         plan_live [0:LIST_SIZE];
	int         plan_next;

	txn_t         send_q [$];
	list_result_t awaited_results [$];
	txn_t         next_txn;
	list_result_t want;

	int issued_cnt   = 0;
	int taken_cnt    = 0;
	int checked_cnt  = 0;
	int mismatch_cnt = 0;
	int placed_cnt   = 0;
	int refused_cnt  = 0;
	int remove_cnt   = 0;
	int dump_cnt     = 0;
	int longest_walk = 0;

	function automatic void owe_result(input logic [5:0] id, input status_t st, input logic fin);
		list_result_t r;
		r.id  = id;
		r.st  = st;
		r.fin = fin;
		awaited_results.push_back(r);
	endfunction

	// Apply one accepted transaction to the shadow list and queue what it must produce.
	task automatic shadow_list_step(input opcode_t op, input logic [5:0] ref_id);
		logic [5:0] nb;
		logic [5:0] pv;
		logic [5:0] nx;
		logic [5:0] cur;
		int         walked;
		bit         known;
		known = (ref_id != 0) && on_list[ref_id];
		case (op)
			OP_INS_RIGHT, OP_INS_LEFT: begin
				// refuse on an absent reference or once every id is handed out
				if (!known || fresh_id > LIST_SIZE) begin
					refused_cnt++;
					owe_result('0, STAT_REFUSED, 1'b1);
				end else begin
					nb = fresh_id[5:0];
					if (op == OP_INS_RIGHT) begin
						nx = nxt_tab[ref_id];
						if (nx != 0)
							prv_tab[nx] = nb;
						nxt_tab[nb]     = nx;
						prv_tab[nb]     = ref_id;
						nxt_tab[ref_id] = nb;
					end else begin
						pv = prv_tab[ref_id];
						if (pv != 0)
							nxt_tab[pv] = nb;
						else
							head_id = nb;
						nxt_tab[nb]     = ref_id;
						prv_tab[nb]     = pv;
						prv_tab[ref_id] = nb;
					end
					on_list[nb] = 1'b1;
					fresh_id++;
					placed_cnt++;
					owe_result(nb, STAT_OK, 1'b1);
				end
			end
			OP_REMOVE: begin
				// an absent node is ignored but still answered
				if (known) begin
					pv = prv_tab[ref_id];
					nx = nxt_tab[ref_id];
					if (pv != 0)
						nxt_tab[pv] = nx;
					if (nx != 0)
						prv_tab[nx] = pv;
					if (head_id == ref_id)
						head_id = nx;
					nxt_tab[ref_id] = '0;
					prv_tab[ref_id] = '0;
					on_list[ref_id] = 1'b0;
				end
				remove_cnt++;
				owe_result('0, STAT_OK, 1'b1);
			end
			default: begin
				dump_cnt++;
				if (head_id == 0) begin
					owe_result('0, STAT_EMPTY, 1'b1);
				end else begin
					walked = 0;
					cur    = head_id;
					while (cur != 0 && walked < MAX_RESULTS) begin
						nx = nxt_tab[cur];
						owe_result(cur, STAT_OK, (nx == 0) || (walked + 1 == MAX_RESULTS));
						walked++;
						cur = nx;
					end
					if (walked > longest_walk)
						longest_walk = walked;
				end
			end
		endcase
	endtask

	function automatic void flag_mismatch(input string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= REPORT_LIMIT)
			$display("%s", msg);
	endfunction

	// Queue a command and track which ids it will leave live.
	task automatic queue_item(input opcode_t op, input logic [5:0] id, input bit drain_first);
		txn_t t;
		t.op          = op;
		t.ref_id      = id;
		t.drain_first = drain_first;
		send_q.push_back(t);
		if ((op == OP_INS_RIGHT || op == OP_INS_LEFT) && id != 0 && plan_live[id]
				&& plan_next <= LIST_SIZE) begin
			plan_live[plan_next] = 1'b1;
			plan_next++;
		end else if (op == OP_REMOVE) begin
			plan_live[id] = 1'b0;
		end
	endtask

	function automatic logic [5:0] pick_live();
		int pool [$];
		for (int i = 1; i <= LIST_SIZE; i++)
			if (plan_live[i])
				pool.push_back(i);
		if (pool.size() == 0)
			return '0;
		return 6'(pool[$urandom_range(0, pool.size() - 1)]);
	endfunction

	// Zero, a removed id or one never handed out.
	function automatic logic [5:0] pick_absent();
		logic [5:0] id;
		if ($urandom_range(0, 3) == 0)
			return '0;
		do
			id = 6'($urandom);
		while (plan_live[id]);
		return id;
	endfunction

	function automatic opcode_t any_insert();
		return ($urandom_range(0, 1) == 0) ? OP_INS_RIGHT : OP_INS_LEFT;
	endfunction

	// Driver: present a transaction at the falling edge and hold it until taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (taken_cnt == issued_cnt) begin
			// nothing in flight; pick the next one unless idling or draining
			if (send_q.size() > 0
					&& !(send_q[0].drain_first && awaited_results.size() > 0)
					&& !($urandom_range(0, 99) < 8 && (issued_cnt < 60 || issued_cnt >= 110))) begin
				next_txn = send_q.pop_front();
				start    <= 1'b1;
				opcode   <= next_txn.op;
				ref_node <= next_txn.ref_id;
				issued_cnt <= issued_cnt + 1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: compare each strobed result, then predict for any accepted transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe) begin
				if (awaited_results.size() == 0) begin
					flag_mismatch($sformatf("unexpected result: id %0d status %0d last %0b",
						node_id, status, last));
				end else begin
					want = awaited_results.pop_front();
					checked_cnt++;
					if (node_id !== want.id || status !== want.st || last !== want.fin)
						flag_mismatch($sformatf(
							"mismatch: expected id %0d status %0d last %0b, got id %0d status %0d last %0b",
							want.id, want.st, want.fin, node_id, status, last));
				end
			end
			if (start && !busy) begin
				taken_cnt <= taken_cnt + 1;
				shadow_list_step(opcode, ref_node);
			end
		end
	end

	initial begin
		for (int i = 0; i <= LIST_SIZE; i++) begin
			nxt_tab[i]   = '0;
			prv_tab[i]   = '0;
			on_list[i]   = 1'b0;
			plan_live[i] = 1'b0;
		end
		on_list[1]   = 1'b1;
		plan_live[1] = 1'b1;
		head_id      = 6'd1;
		fresh_id     = 7'd2;
		plan_next    = 2;

		// Opening moves on the one-node list.
		queue_item(OP_DUMP, 6'($urandom), 1'b0);   // single node, last on the first id
		queue_item(OP_INS_RIGHT, 6'd1, 1'b0);      // 1 2
		queue_item(OP_INS_LEFT, 6'd1, 1'b0);       // 3 1 2, new head
		queue_item(OP_INS_LEFT, 6'd2, 1'b0);       // 3 1 4 2, interior left
		queue_item(OP_INS_RIGHT, 6'd2, 1'b0);      // 3 1 4 2 5, new tail
		queue_item(OP_INS_RIGHT, 6'd0, 1'b0);      // none as reference
		queue_item(OP_INS_LEFT, 6'd63, 1'b0);      // id not handed out yet
		queue_item(OP_INS_RIGHT, 6'd42, 1'b0);
		queue_item(OP_REMOVE, 6'd0, 1'b0);
		queue_item(OP_REMOVE, 6'd63, 1'b0);
		queue_item(OP_DUMP, 6'd63, 1'b1);
		queue_item(OP_REMOVE, 6'd3, 1'b0);         // head goes, 1 takes over
		queue_item(OP_INS_LEFT, 6'd1, 1'b0);       // must not touch the old head's links
		queue_item(OP_DUMP, 6'd0, 1'b0);
		queue_item(OP_REMOVE, 6'd5, 1'b0);         // tail
		queue_item(OP_REMOVE, 6'd4, 1'b0);         // middle
		queue_item(OP_REMOVE, 6'd4, 1'b0);         // already gone
		queue_item(OP_INS_RIGHT, 6'd3, 1'b0);      // removed id as reference
		queue_item(OP_DUMP, 6'($urandom), 1'b0);

		// Grow the list until every id is used; mostly valid references.
		while (plan_next <= LIST_SIZE) begin
			case ($urandom_range(0, 9))
				0:       queue_item(OP_DUMP, 6'($urandom), $urandom_range(0, 99) < 4);
				1:       queue_item(any_insert(), pick_absent(), 1'b0);
				2:       queue_item(OP_REMOVE, pick_absent(), 1'b0);
				default: queue_item(any_insert(), pick_live(), $urandom_range(0, 99) < 4);
			endcase
		end
		queue_item(OP_DUMP, 6'($urandom), 1'b1);   // longest walk
		queue_item(OP_INS_RIGHT, pick_live(), 1'b0);  // full table
		queue_item(OP_INS_LEFT, pick_live(), 1'b0);

		// Churn: removes, dumps and refused inserts on a shrinking list.
		repeat (30) begin
			case ($urandom_range(0, 9))
				0, 1:    queue_item(OP_DUMP, 6'($urandom), $urandom_range(0, 99) < 4);
				2, 3:    queue_item(any_insert(), pick_live(), 1'b0);
				4:       queue_item(OP_REMOVE, pick_absent(), 1'b0);
				default: queue_item(OP_REMOVE, pick_live(), 1'b0);
			endcase
		end

		// Drain to an empty list in random order.
		while (pick_live() != 0) begin
			if ($urandom_range(0, 99) < 15)
				queue_item(OP_DUMP, 6'($urandom), 1'b0);
			queue_item(OP_REMOVE, pick_live(), 1'b0);
		end
		queue_item(OP_DUMP, 6'($urandom), 1'b1);   // empty list
		queue_item(OP_INS_RIGHT, 6'd1, 1'b0);
		queue_item(OP_INS_LEFT, 6'd0, 1'b0);
		queue_item(OP_REMOVE, 6'd7, 1'b0);
		queue_item(OP_DUMP, 6'($urandom), 1'b0);

		// Release reset on a falling edge, clear of the rising edge the design samples on.
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// Wait for every transaction to be taken and every result to come back.
		while (send_q.size() > 0 || issued_cnt != taken_cnt || awaited_results.size() > 0)
			@(posedge clk);
		repeat (MAX_RESULTS + 8) @(posedge clk);
		mismatch_cnt += awaited_results.size();

		$display("ran %0d transactions: %0d inserts placed, %0d refused, %0d removes, %0d dumps",
			taken_cnt, placed_cnt, refused_cnt, remove_cnt, dump_cnt);
		$display("checked %0d results, longest walk %0d ids, %0d mismatches",
			checked_cnt, longest_walk, mismatch_cnt);
		if (mismatch_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog well beyond the slowest legal run.
	initial begin
		#400000;
		$display("FAILURE");
		$finish;
	end

endmodule
